// File: rtl/multichannel_dac_with_dc_blocker_unit_assert.svh
// Assertion macros used by the checker file of this block.
`ifndef MULTICHANNEL_DAC_WITH_DC_BLOCKER_UNIT_ASSERT_SVH
`define MULTICHANNEL_DAC_WITH_DC_BLOCKER_UNIT_ASSERT_SVH

// Overlapping implication, ignored while reset is held.
`define MDAC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mdac assertion failed");

// Next-cycle implication, ignored while reset is held.
`define MDAC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mdac assertion failed");

// Next-cycle implication that is also checked across reset.
`define MDAC_ASSERT_RST(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("mdac reset assertion failed");

`endif

// File: rtl/mdac_pkg.sv
`timescale 1ns / 1ps

package mdac_pkg;

    localparam int LEVEL_W  = 17;
    localparam int ACC_W    = 48;
    localparam int FRAC_W   = 24;
    localparam int COEFF_W  = 24;
    localparam int SAMPLE_W = 16;
    localparam int YQ_W     = 25;

    localparam logic [COEFF_W-1:0] HP_COEFF_RESET = 24'd16771727;

    // Input word opcodes
    typedef enum logic [2:0] {
        ACT_U8_WR  = 3'd0,
        ACT_S8_WR  = 3'd1,
        ACT_U16_WR = 3'd2,
        ACT_RAW_WR = 3'd3,
        ACT_S16_WR = 3'd4,
        ACT_TICK   = 3'd5
    } action_t;

    // Per-channel state write strobes
    typedef struct packed {
        logic level_we;
        logic dc_set;
        logic filt_we;
    } chan_wr_t;

    // Per-channel state read back at the addressed channel
    typedef struct packed {
        logic signed [LEVEL_W-1:0] level;
        logic                      dc_on;
        logic signed [LEVEL_W-1:0] xprev;
        logic signed [ACC_W-1:0]   acc;
    } chan_rd_t;

    // Clamp to the signed 16-bit sample range
    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [YQ_W-1:0] v);
        if (v > 25'sd32767) begin
            return 16'sh7fff;
        end else if (v < -25'sd32768) begin
            return 16'sh8000;
        end else begin
            return v[SAMPLE_W-1:0];
        end
    endfunction

endpackage

// File: rtl/multichannel_dac_with_dc_blocker_unit.sv
`timescale 1ns / 1ps
// Path: a tick word is captured in the input register, then in the result register, and shows on m_*.
// Throughput: one word per cycle while the result register is not stalled; the per-channel
// state read, filter update and write-back happen between the input and result registers.
// Reset: aresetn is synchronous, active low; it clears all channel state, both
// pipeline valids, and loads the default pole coefficient.

module multichannel_dac_with_dc_blocker_unit import mdac_pkg::*; #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // configuration
    input  logic                       cfg_wr_en,
    input  logic [COEFF_W-1:0]         cfg_wr_data,
    // input words
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [2:0]                 s_action,
    input  logic [2:0]                 s_channel_sel,
    input  logic [15:0]                s_write_data,
    // output samples
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [2:0]                 m_sample_channel,
    output logic signed [SAMPLE_W-1:0] m_sample_value
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CH_EXT_W = (IDX_W > 3) ? IDX_W : 3;

    logic [COEFF_W-1:0]         coeff_reg;
    logic                       in_vld_reg;
    logic [2:0]                 in_act_reg;
    logic [2:0]                 in_ch_reg;
    logic [15:0]                in_data_reg;
    logic                       out_vld_reg;
    logic                       out_vld_next;
    logic [2:0]                 out_ch_reg;
    logic signed [SAMPLE_W-1:0] out_val_reg;

    logic [CH_EXT_W-1:0]        ch_ext;
    logic [IDX_W-1:0]           idx;
    logic                       in_range;
    logic signed [LEVEL_W-1:0]  dec_level;
    logic                       dec_level_we;
    logic                       dec_dc_set;
    logic                       dec_tick;
    logic                       emit;
    logic                       out_free;
    logic                       stage_adv;
    chan_wr_t                   wr;
    chan_rd_t                   rd;
    logic signed [ACC_W-1:0]    acc_new;
    logic signed [SAMPLE_W-1:0] hp_y;
    logic signed [SAMPLE_W-1:0] sample;

    // pole coefficient
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coeff_reg <= HP_COEFF_RESET;
        end else if (cfg_wr_en) begin
            coeff_reg <= cfg_wr_data;
        end
    end

    // handshake: the stage moves unless a sample has nowhere to go
    assign ch_ext    = CH_EXT_W'(in_ch_reg);
    assign idx       = ch_ext[IDX_W-1:0];
    assign in_range  = 32'(in_ch_reg) < NUM_CHANNELS;
    assign emit      = in_range && dec_tick;
    assign out_free  = !out_vld_reg || m_ready;
    assign stage_adv = in_vld_reg && (!emit || out_free);
    assign s_ready   = !in_vld_reg || stage_adv;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_act_reg  <= s_action;
            in_ch_reg   <= s_channel_sel;
            in_data_reg <= s_write_data;
        end
    end

    mdac_level_dec u_dec (
        .action     (in_act_reg),
        .write_data (in_data_reg),
        .level      (dec_level),
        .level_we   (dec_level_we),
        .dc_set     (dec_dc_set),
        .tick       (dec_tick)
    );

    // state write strobes
    assign wr.level_we = stage_adv && in_range && dec_level_we;
    assign wr.dc_set   = stage_adv && in_range && dec_dc_set;
    assign wr.filt_we  = stage_adv && emit && rd.dc_on;

    mdac_chan_state #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .IDX_W        (IDX_W)
    ) u_state (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .idx      (idx),
        .wr       (wr),
        .level_in (dec_level),
        .xprev_in (rd.level),
        .acc_in   (acc_new),
        .rd       (rd)
    );

    mdac_hp_step u_hp (
        .coeff   (coeff_reg),
        .acc_in  (rd.acc),
        .x       (rd.level),
        .xprev   (rd.xprev),
        .acc_out (acc_new),
        .y       (hp_y)
    );

    // filtered or plain held level
    assign sample = rd.dc_on ? hp_y
                             : sat16({{(YQ_W-LEVEL_W){rd.level[LEVEL_W-1]}}, rd.level});

    // result register
    assign out_vld_next = (out_vld_reg && !m_ready) || (stage_adv && emit);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_adv && emit) begin
            out_ch_reg  <= in_ch_reg;
            out_val_reg <= sample;
        end
    end

    assign m_valid          = out_vld_reg;
    assign m_sample_channel = out_ch_reg;
    assign m_sample_value   = out_val_reg;

endmodule

// File: rtl/mdac_level_dec.sv
`timescale 1ns / 1ps

module mdac_level_dec import mdac_pkg::*; (
    input  logic [2:0]                action,
    input  logic [15:0]               write_data,
    output logic signed [LEVEL_W-1:0] level,
    output logic                      level_we,
    output logic                      dc_set,
    output logic                      tick
);

    action_t    act;
    logic [7:0] b;

    assign act = action_t'(action);
    assign b   = write_data[7:0];

    // Map each write format onto the 17-bit signed held level
    always_comb begin
        level    = '0;
        level_we = 1'b0;
        dc_set   = 1'b0;
        tick     = 1'b0;
        case (act)
            ACT_U8_WR: begin
                // (b*257)/2
                level    = {2'b00, b, b[7:1]};
                level_we = 1'b1;
            end
            ACT_S8_WR: begin
                // b*257 - 0x8000
                level    = {~b[7], ~b[7], b[6:0], b};
                level_we = 1'b1;
            end
            ACT_U16_WR: begin
                level    = {2'b00, write_data[15:1]};
                level_we = 1'b1;
            end
            ACT_RAW_WR: begin
                level    = {1'b0, write_data};
                level_we = 1'b1;
                dc_set   = 1'b1;
            end
            ACT_S16_WR: begin
                level    = {~write_data[15], ~write_data[15], write_data[14:0]};
                level_we = 1'b1;
            end
            ACT_TICK: begin
                tick = 1'b1;
            end
            default: begin
                // undefined opcodes do nothing
                tick = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/mdac_hp_step.sv
`timescale 1ns / 1ps

module mdac_hp_step import mdac_pkg::*; (
    input  logic [COEFF_W-1:0]         coeff,
    input  logic signed [ACC_W-1:0]    acc_in,
    input  logic signed [LEVEL_W-1:0]  x,
    input  logic signed [LEVEL_W-1:0]  xprev,
    output logic signed [ACC_W-1:0]    acc_out,
    output logic signed [SAMPLE_W-1:0] y
);

    logic                     neg;
    logic [ACC_W-1:0]         mag;
    logic [FRAC_W-1:0]        hi;
    logic [FRAC_W-1:0]        lo;
    logic [ACC_W-1:0]         p_hi;
    logic [ACC_W-1:0]         p_lo;
    logic [ACC_W-1:0]         prod;
    logic signed [ACC_W:0]    sprod;
    logic signed [LEVEL_W:0]  diff;
    logic signed [ACC_W+1:0]  sum;
    logic [ACC_W-1:0]         amag;
    logic [FRAC_W-1:0]        q;
    logic signed [YQ_W-1:0]   yq;

    // R * acc on the magnitude, split into two 24x24 products
    assign neg  = acc_in[ACC_W-1];
    assign mag  = neg ? (ACC_W'(0) - ACC_W'(acc_in)) : ACC_W'(acc_in);
    assign hi   = mag[ACC_W-1:FRAC_W];
    assign lo   = mag[FRAC_W-1:0];
    assign p_hi = ACC_W'(hi) * ACC_W'(coeff);
    assign p_lo = ACC_W'(lo) * ACC_W'(coeff);
    assign prod = p_hi + {{(ACC_W-FRAC_W){1'b0}}, p_lo[ACC_W-1:FRAC_W]};

    // sign back, then add the input step scaled by 2^24
    assign sprod = neg ? -$signed({1'b0, prod}) : $signed({1'b0, prod});
    assign diff  = {x[LEVEL_W-1], x} - {xprev[LEVEL_W-1], xprev};
    assign sum   = {sprod[ACC_W], sprod}
                 + {{(ACC_W+2-(LEVEL_W+1)-FRAC_W){diff[LEVEL_W]}}, diff, {FRAC_W{1'b0}}};

    // clamp to the signed 48-bit accumulator range
    always_comb begin
        if (sum[ACC_W+1:ACC_W-1] == 3'b000 || sum[ACC_W+1:ACC_W-1] == 3'b111) begin
            acc_out = sum[ACC_W-1:0];
        end else if (sum[ACC_W+1]) begin
            acc_out = {1'b1, {(ACC_W-1){1'b0}}};
        end else begin
            acc_out = {1'b0, {(ACC_W-1){1'b1}}};
        end
    end

    // drop the fraction toward zero, then clamp to 16 bits
    assign amag = acc_out[ACC_W-1] ? (ACC_W'(0) - ACC_W'(acc_out)) : ACC_W'(acc_out);
    assign q    = amag[ACC_W-1:FRAC_W];
    assign yq   = acc_out[ACC_W-1] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    assign y    = sat16(yq);

endmodule

// File: rtl/mdac_chan_state.sv
`timescale 1ns / 1ps

module mdac_chan_state import mdac_pkg::*; #(
    parameter int NUM_CHANNELS = 8,
    parameter int IDX_W        = 3
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [IDX_W-1:0]          idx,
    input  chan_wr_t                  wr,
    input  logic signed [LEVEL_W-1:0] level_in,
    input  logic signed [LEVEL_W-1:0] xprev_in,
    input  logic signed [ACC_W-1:0]   acc_in,
    output chan_rd_t                  rd
);

    logic signed [LEVEL_W-1:0] level_reg [NUM_CHANNELS];
    logic                      dc_on_reg [NUM_CHANNELS];
    logic signed [LEVEL_W-1:0] xprev_reg [NUM_CHANNELS];
    logic signed [ACC_W-1:0]   acc_reg   [NUM_CHANNELS];

    // read side at the addressed channel
    assign rd.level = level_reg[idx];
    assign rd.dc_on = dc_on_reg[idx];
    assign rd.xprev = xprev_reg[idx];
    assign rd.acc   = acc_reg[idx];

    // channel state, cleared on reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                level_reg[i] <= '0;
                dc_on_reg[i] <= 1'b0;
                xprev_reg[i] <= '0;
                acc_reg[i]   <= '0;
            end
        end else begin
            if (wr.level_we) begin
                level_reg[idx] <= level_in;
            end
            if (wr.dc_set) begin
                dc_on_reg[idx] <= 1'b1;
            end
            if (wr.filt_we) begin
                xprev_reg[idx] <= xprev_in;
                acc_reg[idx]   <= acc_in;
            end
        end
    end

endmodule

// File: rtl/mdac_checker.sv
`timescale 1ns / 1ps
`include "multichannel_dac_with_dc_blocker_unit_assert.svh"

module mdac_checker import mdac_pkg::*; #(
    parameter int NUM_CHANNELS = 8
) (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic [2:0]                 s_action,
    input logic [2:0]                 s_channel_sel,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [2:0]                 m_sample_channel,
    input logic signed [SAMPLE_W-1:0] m_sample_value
);

    // a stalled sample holds
    `MDAC_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_sample_value) && $stable(m_sample_channel))

    // nothing comes out right after reset
    `MDAC_ASSERT_RST(a_rst_quiet, aclk, !aresetn, !m_valid)

    // a non-tick word never produces a sample
    `MDAC_ASSERT_NXT(a_no_spurious, aclk, aresetn, (s_valid && s_ready && s_action != ACT_TICK) ##1 !m_valid, !m_valid)

    // an in-range tick shows its sample with its channel when the output is free after acceptance
    `MDAC_ASSERT_NXT(a_tick_out, aclk, aresetn, (s_valid && s_ready && s_action == ACT_TICK && 32'(s_channel_sel) < NUM_CHANNELS) ##1 !m_valid, m_valid && m_sample_channel == $past(s_channel_sel, 2))

endmodule

bind multichannel_dac_with_dc_blocker_unit mdac_checker #(
    .NUM_CHANNELS (NUM_CHANNELS)
) u_mdac_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .s_action         (s_action),
    .s_channel_sel    (s_channel_sel),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_sample_channel (m_sample_channel),
    .m_sample_value   (m_sample_value)
);

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import mdac_pkg::*;

    localparam int          NUM_CH        = 8;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned SETTLE_CYCLES = 4;     // pipeline drain plus margin
    localparam int unsigned HOLD_OFF      = 300;   // long receiver stall
    localparam int          MAX_REPORTS   = 10;
    localparam int          LEVEL_8B_MUL  = 257;
    localparam int          LEVEL_OFFSET  = 32768;

    // opcodes the block does not define; it must drop them silently
    localparam logic [2:0] ACT_UNDEF_LO = 3'd6;
    localparam logic [2:0] ACT_UNDEF_HI = 3'd7;

    typedef struct packed {
        logic [2:0]                 ch;
        logic signed [SAMPLE_W-1:0] value;
    } dac_sample_t;

    // Expected-sample store plus its own copy of the channel bank
    class dac_sample_board;
        logic [COEFF_W-1:0]        pole;
        logic signed [LEVEL_W-1:0] level [NUM_CH];
        bit                        dc_on [NUM_CH];
        logic signed [LEVEL_W-1:0] xprev [NUM_CH];
        logic signed [ACC_W-1:0]   acc   [NUM_CH];
        dac_sample_t               expected_samples [$];
        int unsigned               checked;
        int unsigned               errors;

        function new();
            pole = HP_COEFF_RESET;
            for (int i = 0; i < NUM_CH; i++) begin
                level[i] = '0;
                dc_on[i] = 1'b0;
                xprev[i] = '0;
                acc[i]   = '0;
            end
            checked = 0;
            errors  = 0;
        endfunction

        function void set_pole(logic [COEFF_W-1:0] r);
            pole = r;
        endfunction

        function int unsigned pending();
            return expected_samples.size();
        endfunction

        // R * a on the magnitude, truncated toward zero, sign restored
        function logic signed [ACC_W-1:0] pole_scale(logic signed [ACC_W-1:0] a);
            logic [ACC_W-1:0] mag;
            logic [63:0]      prod;
            mag  = a[ACC_W-1] ? -a : a;
            prod = 64'(mag[ACC_W-1:FRAC_W]) * 64'(pole)
                 + ((64'(mag[FRAC_W-1:0]) * 64'(pole)) >> FRAC_W);
            return a[ACC_W-1] ? -prod[ACC_W-1:0] : prod[ACC_W-1:0];
        endfunction

        // One high-pass update; returns the integer part, truncated toward zero
        function longint highpass_step(int ch);
            longint sum;
            longint acc_hi;
            longint acc_lo;
            acc_hi = (longint'(1) << (ACC_W - 1)) - 1;
            acc_lo = -(longint'(1) << (ACC_W - 1));
            sum = longint'(pole_scale(acc[ch]))
                + ((longint'(level[ch]) - longint'(xprev[ch])) <<< FRAC_W);
            if (sum > acc_hi) sum = acc_hi;
            if (sum < acc_lo) sum = acc_lo;
            acc[ch]   = sum[ACC_W-1:0];
            xprev[ch] = level[ch];
            return (sum < 0) ? -((-sum) >> FRAC_W) : (sum >> FRAC_W);
        endfunction

        function logic signed [SAMPLE_W-1:0] clamp16(longint v);
            if (v > 32767) return 16'sh7fff;
            if (v < -32768) return 16'sh8000;
            return v[SAMPLE_W-1:0];
        endfunction

        // Accepted input word: update the bank, queue a sample on a tick
        function void note_word(logic [2:0] act, logic [2:0] ch, logic [15:0] data);
            int          b;
            int          d;
            dac_sample_t s;
            b = int'(data[7:0]);
            d = int'(data);
            case (act)
                ACT_U8_WR:  level[ch] = LEVEL_W'((b * LEVEL_8B_MUL) / 2);
                ACT_S8_WR:  level[ch] = LEVEL_W'(b * LEVEL_8B_MUL - LEVEL_OFFSET);
                ACT_U16_WR: level[ch] = LEVEL_W'(d >> 1);
                ACT_RAW_WR: begin
                    level[ch] = LEVEL_W'(d);
                    dc_on[ch] = 1'b1;
                end
                ACT_S16_WR: level[ch] = LEVEL_W'(d - LEVEL_OFFSET);
                ACT_TICK: begin
                    s.ch    = ch;
                    s.value = dc_on[ch] ? clamp16(highpass_step(ch))
                                        : clamp16(longint'(level[ch]));
                    expected_samples.push_back(s);
                end
                default: ;
            endcase
        endfunction

        // Accepted output word against the oldest expected sample
        function void check_sample(logic [2:0] ch, logic signed [SAMPLE_W-1:0] value);
            dac_sample_t want;
            if (expected_samples.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected sample: ch %0d value %0d", ch, value);
                return;
            end
            want = expected_samples.pop_front();
            checked++;
            if (want.ch !== ch || want.value !== value) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("sample mismatch: ch exp %0d got %0d, value exp %0d got %0d",
                             want.ch, ch, want.value, value);
            end
        endfunction
    endclass

    logic                       aclk;
    logic                       aresetn       = 1'b0;
    logic                       cfg_wr_en     = 1'b0;
    logic [COEFF_W-1:0]         cfg_wr_data   = HP_COEFF_RESET;
    logic                       s_valid       = 1'b0;
    logic                       s_ready;
    logic [2:0]                 s_action      = ACT_U8_WR;
    logic [2:0]                 s_channel_sel = 3'd0;
    logic [15:0]                s_write_data  = 16'h0000;
    logic                       m_valid;
    logic                       m_ready       = 1'b0;
    logic [2:0]                 m_sample_channel;
    logic signed [SAMPLE_W-1:0] m_sample_value;

    dac_sample_board sb = new();

    action_t     write_kinds [5] = '{ACT_U8_WR, ACT_S8_WR, ACT_U16_WR, ACT_RAW_WR, ACT_S16_WR};
    int unsigned burst_left      = 0;
    bit          no_gaps         = 1'b0;
    bit          rx_hold_pending = 1'b0;
    int unsigned words_sent      = 0;
    int unsigned ticks_sent      = 0;
    int unsigned pole_settings   = 1;
    int unsigned cycle_count     = 0;

    multichannel_dac_with_dc_blocker_unit #(
        .NUM_CHANNELS (NUM_CH)
    ) u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_channel_sel    (s_channel_sel),
        .s_write_data     (s_write_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_sample_channel (m_sample_channel),
        .m_sample_value   (m_sample_value)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Watchdog
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("[multichannel_dac_with_dc_blocker_unit] ERROR");
        $finish;
    end

    // Receiver: runs of always-ready, coin-flip, mostly-stalled and mostly-ready,
    // plus one long hold-off on request
    initial begin : rx_ready_gen
        int unsigned style;
        int unsigned run_len;
        @(posedge aclk);
        forever begin
            if (rx_hold_pending) begin
                rx_hold_pending = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_OFF) @(posedge aclk);
            end
            style   = $urandom_range(0, 3);
            run_len = $urandom_range(5, 60);
            repeat (run_len) begin
                case (style)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    2:       m_ready <= ($urandom_range(0, 7) == 0);
                    default: m_ready <= ($urandom_range(0, 3) != 0);
                endcase
                @(posedge aclk);
            end
        end
    end

    // Output monitor: signals are stable at the falling edge, so a word seen
    // here with valid and ready high is taken at the next rising edge
    initial begin : sample_monitor
        forever begin
            @(negedge aclk);
            if (aresetn && m_valid && m_ready)
                sb.check_sample(m_sample_channel, m_sample_value);
        end
    end

    // Offer one word, with a random gap at the start of each burst
    task automatic send_word(input logic [2:0] act, input logic [2:0] ch,
                             input logic [15:0] data);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid       <= 1'b1;
        s_action      <= act;
        s_channel_sel <= ch;
        s_write_data  <= data;
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        @(posedge aclk);
        sb.note_word(act, ch, data);
        words_sent++;
        if (act == ACT_TICK) ticks_sent++;
    endtask

    // Stop offering and wait for every expected sample, then let the pipe settle
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic load_pole(input logic [COEFF_W-1:0] r);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= r;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.set_pole(r);
        pole_settings++;
    endtask

    // Field extremes on a plain channel, then a DC channel, dropped opcodes and an unwritten channel
    task automatic directed_words();
        send_word(ACT_U8_WR,  3'd0, 16'hFF00);
        send_word(ACT_TICK,   3'd0, 16'h0000);
        send_word(ACT_U8_WR,  3'd0, 16'h00FF);
        send_word(ACT_TICK,   3'd0, 16'h0000);
        send_word(ACT_S8_WR,  3'd0, 16'h5A00);
        send_word(ACT_TICK,   3'd0, 16'h0000);
        send_word(ACT_S8_WR,  3'd0, 16'h00FF);
        send_word(ACT_TICK,   3'd0, 16'h0000);
        send_word(ACT_U16_WR, 3'd0, 16'hFFFF);
        send_word(ACT_TICK,   3'd0, 16'h0000);
        send_word(ACT_U16_WR, 3'd0, 16'h0000);
        send_word(ACT_TICK,   3'd0, 16'h0000);
        send_word(ACT_S16_WR, 3'd0, 16'h0000);
        send_word(ACT_TICK,   3'd0, 16'h0000);
        send_word(ACT_S16_WR, 3'd0, 16'hFFFF);
        send_word(ACT_TICK,   3'd0, 16'h0000);
        // full-scale raw step saturates the output, then steps back down
        send_word(ACT_RAW_WR, 3'd7, 16'hFFFF);
        send_word(ACT_TICK,   3'd7, 16'h0000);
        send_word(ACT_TICK,   3'd7, 16'h0000);
        send_word(ACT_RAW_WR, 3'd7, 16'h0000);
        send_word(ACT_TICK,   3'd7, 16'h0000);
        send_word(ACT_TICK,   3'd7, 16'h0000);
        send_word(ACT_UNDEF_LO, 3'd5, 16'hA5A5);
        send_word(ACT_UNDEF_HI, 3'd5, 16'h5A5A);
        // channel never written
        send_word(ACT_TICK,   3'd3, 16'h0000);
        drain();
    endtask

    // Mostly a write followed by a few ticks on the same channel, some noise.
    // Until raw_any, raw writes stay on channels 4..7 so 0..3 keep plain output.
    task automatic run_phase(input int unsigned n_words, input bit raw_any,
                             input bit with_hold);
        int unsigned done_words;
        int unsigned n_ticks;
        logic [2:0]  ch;
        logic [2:0]  act;
        logic [15:0] data;
        done_words = 0;
        if (with_hold) begin
            rx_hold_pending = 1'b1;
            no_gaps         = 1'b1;
        end
        while (done_words < n_words) begin
            if (done_words >= 64) no_gaps = 1'b0;
            ch = 3'($urandom_range(0, NUM_CH - 1));
            case ($urandom_range(0, 7))
                0:       data = 16'h0000;
                1:       data = 16'hFFFF;
                default: data = 16'($urandom);
            endcase
            if ($urandom_range(0, 9) < 8)
                act = write_kinds[$urandom_range(0, 4)];
            else
                act = 3'($urandom_range(0, 7));
            if (act == ACT_RAW_WR && !raw_any && !ch[2])
                act = ACT_S16_WR;
            send_word(act, ch, data);
            if (act != ACT_UNDEF_LO && act != ACT_UNDEF_HI) done_words++;
            if (act != ACT_TICK && act != ACT_UNDEF_LO && act != ACT_UNDEF_HI) begin
                n_ticks = $urandom_range(1, 4);
                repeat (n_ticks) send_word(ACT_TICK, ch, 16'($urandom));
                done_words += n_ticks;
            end
        end
        no_gaps = 1'b0;
        drain();
    endtask

    initial begin : main_seq
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        directed_words();
        run_phase(180, 1'b0, 1'b0);
        load_pole('0);
        run_phase(170, 1'b0, 1'b1);
        load_pole('1);
        run_phase(170, 1'b0, 1'b0);
        load_pole(COEFF_W'($urandom));
        run_phase(170, 1'b0, 1'b0);
        load_pole(HP_COEFF_RESET);
        run_phase(180, 1'b1, 1'b0);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("run covered %0d words (%0d ticks) over %0d pole settings incl. 0 and max",
                 words_sent, ticks_sent, pole_settings);
        $display("%0d samples compared, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("[multichannel_dac_with_dc_blocker_unit] OK");
        end else begin
            $display("[multichannel_dac_with_dc_blocker_unit] ERROR");
        end
        $finish;
    end

endmodule
